// ===== hdl/naive_bayes_pixel_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NAIVE_BAYES_PIXEL_CLASSIFIER_DEFINES_SVH
`define NAIVE_BAYES_PIXEL_CLASSIFIER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define NBPC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nbpc implication check failed");

// condition must never hold
`define NBPC_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("nbpc forbidden condition seen");

`endif

// ===== hdl/nbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier package
// Command and status types, class codes, log2 table and helper functions.
// ----------------------------------------------------------------------------
package nbpc_pkg;

   // action codes of the input stream
   typedef enum logic [1:0] {
      ACT_CLEAR    = 2'd0,
      ACT_TRAIN    = 2'd1,
      ACT_CLASSIFY = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   // class of a log value: finite, +inf, -inf, undefined
   typedef enum logic [1:0] {
      CL_FIN  = 2'd0,
      CL_PINF = 2'd1,
      CL_NINF = 2'd2,
      CL_NAN  = 2'd3
   } lclass_type;

   localparam int IDX_MAX_W = 24;        // table index width at the largest image
   localparam int LG_W      = 13;        // unsigned Q8 log2 of a 32-bit count
   localparam int DIFF_W    = LG_W + 1;  // signed difference of two logs
   localparam int ACC_W     = 32;
   localparam int SCORE_W   = 24;
   localparam int RSP_DEPTH = 8;         // result queue depth
   localparam logic signed [17:0] LN2_Q16   = 18'sd45426;
   localparam logic signed [17:0] ROUND_Q16 = 18'sd32768;

   // one table operation handed from front to back
   typedef struct packed {
      action_type           op;
      logic [IDX_MAX_W-1:0] idx;
      logic                 label;
      logic                 last;
   } cmd_type;

   // back status seen by front and top
   typedef struct packed {
      logic clearing;
      logic cmd_pop;
   } back_status_type;

   typedef logic [7:0] frac_table_type [256];

   // fraction bits of log2((256+m)/256), squaring method in Q1.30
   function automatic frac_table_type build_frac_table();
      frac_table_type t;
      logic [63:0]    v;
      logic [7:0]     f;
      for (int m = 0; m < 256; m++) begin
         v = 64'(256 + m) << 22;
         f = 8'd0;
         for (int i = 0; i < 8; i++) begin
            v = (v * v) >> 30;
            f = {f[6:0], 1'b0};
            if (v >= (64'd2 << 30)) begin
               f[0] = 1'b1;
               v    = v >> 1;
            end
         end
         t[m] = f;
      end
      return t;
   endfunction

   localparam frac_table_type FRAC_TABLE = build_frac_table();

   // Q8 log2: leading-one position and table fraction; zero maps to zero
   function automatic logic [LG_W-1:0] lg_q8(input logic [31:0] x);
      logic [4:0]  e;
      logic [39:0] w;
      logic [7:0]  m;
      e = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) e = 5'(i);
      end
      w = {x, 8'd0} >> e;
      m = w[7:0];
      return (x == 32'd0) ? '0 : {e, FRAC_TABLE[m]};
   endfunction

   // class of log(c/n)
   function automatic lclass_type log_class(input logic c_zero, input logic n_zero);
      if (n_zero) return c_zero ? CL_NAN : CL_PINF;
      return c_zero ? CL_NINF : CL_FIN;
   endfunction

   function automatic lclass_type sub_class(input lclass_type a, input lclass_type b);
      if (a == CL_NAN || b == CL_NAN) return CL_NAN;
      if (a == CL_PINF) return (b == CL_PINF) ? CL_NAN : CL_PINF;
      if (a == CL_NINF) return (b == CL_NINF) ? CL_NAN : CL_NINF;
      if (b == CL_PINF) return CL_NINF;
      if (b == CL_NINF) return CL_PINF;
      return CL_FIN;
   endfunction

   function automatic lclass_type add_class(input lclass_type a, input lclass_type b);
      if (a == CL_NAN || b == CL_NAN) return CL_NAN;
      if (a == CL_FIN) return b;
      if (b == CL_FIN || b == a) return a;
      return CL_NAN;
   endfunction

endpackage

// ===== hdl/nbpc_if.sv =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier channels
// Pixel request and score response streams with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nbpc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [3:0] gray_level;
   logic       label;
   logic       last_pixel;

   modport source (output valid, action, gray_level, label, last_pixel, input ready);
   modport sink   (input valid, action, gray_level, label, last_pixel, output ready);
endinterface

interface nbpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] score;
   logic [1:0]         score_class;

   modport source (output valid, score, score_class, input ready);
   modport sink   (input valid, score, score_class, output ready);
endinterface

// ===== hdl/nbpc_fifo.sv =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier queue
// Small register FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
module nbpc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule

// ===== hdl/nbpc_front.sv =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier front end
// Accepts pixels, tracks the pixel position and forms table commands.
// ----------------------------------------------------------------------------
module nbpc_front #(
   parameter int PIXELS      = 1024,
   parameter int GRAY_LEVELS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   nbpc_req_if.sink                req,
   input  nbpc_pkg::back_status_type status,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output nbpc_pkg::cmd_type       cmd
);
   localparam int TABLE_SIZE = PIXELS * GRAY_LEVELS;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int POS_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int SUM_W      = IDX_W + 9;
   localparam logic [8:0] GRAY_MAX = 9'(GRAY_LEVELS - 1);

   nbpc_pkg::action_type op;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [8:0]       gray_ext, gray_clamped;
   logic             accept, wrap;

   assign op        = nbpc_pkg::action_type'(req.action);
   assign req.ready = cmd_ready && !status.clearing;
   assign accept    = req.valid && req.ready;
   assign cmd_valid = accept && (op != nbpc_pkg::ACT_NONE);

   // gray level clamp and table index
   assign gray_ext     = {5'd0, req.gray_level};
   assign gray_clamped = (gray_ext >= 9'(GRAY_LEVELS)) ? GRAY_MAX : gray_ext;
   always_comb begin
      cmd.op    = op;
      cmd.idx   = nbpc_pkg::IDX_MAX_W'(IDX_W'(SUM_W'(base_ff) + SUM_W'(gray_clamped)));
      cmd.label = req.label;
      cmd.last  = req.last_pixel;
   end

   // next pixel position
   assign wrap = req.last_pixel || (pos_ff == POS_W'(PIXELS - 1));
   always_comb begin
      pos_in  = pos_ff;
      base_in = base_ff;
      unique case (op)
         nbpc_pkg::ACT_CLEAR: begin
            pos_in  = '0;
            base_in = '0;
         end
         nbpc_pkg::ACT_TRAIN, nbpc_pkg::ACT_CLASSIFY: begin
            pos_in  = wrap ? '0 : pos_ff + 1'b1;
            base_in = wrap ? '0 : IDX_W'(SUM_W'(base_ff) + SUM_W'(GRAY_LEVELS));
         end
         default: begin
            pos_in  = pos_ff;
            base_in = base_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         base_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         base_ff <= base_in;
      end
   end
endmodule

// ===== hdl/nbpc_back.sv =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier back end
// Count tables with read-modify-write, score accumulation and final scaling.
// ----------------------------------------------------------------------------
module nbpc_back #(
   parameter int PIXELS      = 1024,
   parameter int GRAY_LEVELS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  nbpc_pkg::cmd_type         cmd,
   output nbpc_pkg::back_status_type status,
   output logic                      res_valid,
   output logic signed [23:0]        res_score,
   output logic [1:0]                res_class,
   input  logic                      rsp_taken
);
   localparam int TABLE_SIZE = PIXELS * GRAY_LEVELS;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CRED_W     = $clog2(nbpc_pkg::RSP_DEPTH + 1);
   localparam int DW         = nbpc_pkg::DIFF_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic signed [17:0]   PIX_S     = 18'(PIXELS);
   localparam logic signed [33:0]   ACC_MAX   = 34'sd2147483647;
   localparam logic signed [33:0]   ACC_MIN   = -34'sd2147483648;
   localparam logic signed [33:0]   SCORE_MAX = 34'sd8388607;
   localparam logic signed [33:0]   SCORE_MIN = -34'sd8388608;

   // clearing sweep and result credits
   logic             clearing_ff;
   logic [IDX_W-1:0] clr_addr_ff;
   logic [CRED_W-1:0] credits_ff;
   logic             makes_result, pop;

   assign makes_result = (cmd.op == nbpc_pkg::ACT_CLASSIFY) && cmd.last;
   assign pop = cmd_valid && !clearing_ff &&
                (!makes_result || credits_ff != CRED_W'(nbpc_pkg::RSP_DEPTH));
   assign status.clearing = clearing_ff;
   assign status.cmd_pop  = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         credits_ff  <= '0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_W'(TABLE_SIZE - 1)) clearing_ff <= 1'b0;
         end else if (pop && cmd.op == nbpc_pkg::ACT_CLEAR) begin
            clearing_ff <= 1'b1;
            clr_addr_ff <= '0;
         end
         credits_ff <= credits_ff + CRED_W'(pop && makes_result) - CRED_W'(rsp_taken);
      end
   end

   // count tables
   logic [COUNT_BITS-1:0] table0_mem [TABLE_SIZE];
   logic [COUNT_BITS-1:0] table1_mem [TABLE_SIZE];
   logic [COUNT_BITS-1:0] rd0_ff, rd1_ff;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] wr0_data, wr1_data;
   logic                  we0, we1;

   assign rd_addr = cmd.idx[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (we0) table0_mem[wr_addr] <= wr0_data;
      rd0_ff <= table0_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) table1_mem[wr_addr] <= wr1_data;
      rd1_ff <= table1_mem[rd_addr];
   end

   // stage 1: counts with forwarding, count update, log terms
   logic                  s1_valid_ff;
   nbpc_pkg::cmd_type     s1_cmd_ff;
   logic                  fw0_valid_ff, fw1_valid_ff;
   logic [IDX_W-1:0]      fw_idx_ff;
   logic [COUNT_BITS-1:0] fw0_val_ff, fw1_val_ff;
   logic [COUNT_BITS-1:0] img0_ff, img1_ff;
   logic [COUNT_BITS-1:0] c0, c1, inc0, inc1;
   logic [IDX_W-1:0]      s1_idx;
   logic                  s1_train, s1_classify, s1_clear, tr0, tr1;
   nbpc_pkg::lclass_type  pix_class;
   logic signed [DW-1:0]  pix_diff;

   assign s1_idx      = s1_cmd_ff.idx[IDX_W-1:0];
   assign s1_train    = s1_valid_ff && (s1_cmd_ff.op == nbpc_pkg::ACT_TRAIN);
   assign s1_classify = s1_valid_ff && (s1_cmd_ff.op == nbpc_pkg::ACT_CLASSIFY);
   assign s1_clear    = s1_valid_ff && (s1_cmd_ff.op == nbpc_pkg::ACT_CLEAR);
   assign tr0         = s1_train && !s1_cmd_ff.label;
   assign tr1         = s1_train && s1_cmd_ff.label;

   assign c0   = (fw0_valid_ff && fw_idx_ff == s1_idx) ? fw0_val_ff : rd0_ff;
   assign c1   = (fw1_valid_ff && fw_idx_ff == s1_idx) ? fw1_val_ff : rd1_ff;
   assign inc0 = (c0 == COUNT_MAX) ? COUNT_MAX : c0 + 1'b1;
   assign inc1 = (c1 == COUNT_MAX) ? COUNT_MAX : c1 + 1'b1;

   assign we0      = clearing_ff || tr0;
   assign we1      = clearing_ff || tr1;
   assign wr_addr  = clearing_ff ? clr_addr_ff : s1_idx;
   assign wr0_data = clearing_ff ? '0 : inc0;
   assign wr1_data = clearing_ff ? '0 : inc1;

   assign pix_class = nbpc_pkg::sub_class(
                         nbpc_pkg::log_class(c1 == '0, img1_ff == '0),
                         nbpc_pkg::log_class(c0 == '0, img0_ff == '0));
   assign pix_diff  = $signed({1'b0, nbpc_pkg::lg_q8(32'(c1))}) -
                      $signed({1'b0, nbpc_pkg::lg_q8(32'(c0))});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fw0_valid_ff <= 1'b0;
         fw1_valid_ff <= 1'b0;
         img0_ff      <= '0;
         img1_ff      <= '0;
      end else begin
         s1_valid_ff  <= pop;
         fw0_valid_ff <= tr0 && !clearing_ff;
         fw1_valid_ff <= tr1 && !clearing_ff;
         if (s1_clear) begin
            img0_ff <= '0;
            img1_ff <= '0;
         end else if (s1_train && s1_cmd_ff.last) begin
            if (s1_cmd_ff.label) img1_ff <= (img1_ff == COUNT_MAX) ? COUNT_MAX : img1_ff + 1'b1;
            else                 img0_ff <= (img0_ff == COUNT_MAX) ? COUNT_MAX : img0_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff  <= cmd;
      fw_idx_ff  <= s1_idx;
      fw0_val_ff <= inc0;
      fw1_val_ff <= inc1;
   end

   // stage 2: accumulate over the image
   logic                     s2_valid_ff, s2_last_ff;
   nbpc_pkg::action_type     s2_op_ff;
   nbpc_pkg::lclass_type     s2_class_ff;
   logic signed [DW-1:0]     s2_diff_ff;
   logic signed [31:0]       acc_ff, acc_new;
   nbpc_pkg::lclass_type     acc_class_ff, class_new;
   logic signed [33:0]       acc_sum;
   logic signed [DW-1:0]     prior_lg;

   assign acc_sum   = 34'(acc_ff) + 34'(s2_diff_ff);
   assign class_new = nbpc_pkg::add_class(acc_class_ff, s2_class_ff);
   always_comb begin
      acc_new = acc_ff;
      if (s2_class_ff == nbpc_pkg::CL_FIN) begin
         priority if (acc_sum > ACC_MAX) acc_new = 32'(ACC_MAX);
         else if (acc_sum < ACC_MIN)     acc_new = 32'(ACC_MIN);
         else                            acc_new = 32'(acc_sum);
      end
   end
   assign prior_lg = $signed({1'b0, nbpc_pkg::lg_q8(32'(img0_ff))}) -
                     $signed({1'b0, nbpc_pkg::lg_q8(32'(img1_ff))});

   logic                 s3_valid_ff;
   logic signed [31:0]   s3_acc_ff;
   nbpc_pkg::lclass_type s3_class_ff;
   logic signed [DW-1:0] s3_prior_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         acc_class_ff <= nbpc_pkg::CL_FIN;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_last_ff && (s2_op_ff == nbpc_pkg::ACT_CLASSIFY);
         if (s2_valid_ff) begin
            if (s2_op_ff == nbpc_pkg::ACT_CLEAR || s2_last_ff) begin
               acc_ff       <= '0;
               acc_class_ff <= nbpc_pkg::CL_FIN;
            end else if (s2_op_ff == nbpc_pkg::ACT_CLASSIFY) begin
               acc_ff       <= acc_new;
               acc_class_ff <= class_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff    <= s1_cmd_ff.op;
      s2_last_ff  <= s1_cmd_ff.last;
      s2_class_ff <= pix_class;
      s2_diff_ff  <= pix_diff;
      s3_acc_ff   <= acc_new;
      s3_class_ff <= class_new;
      s3_prior_ff <= prior_lg;
   end

   // stages 3 to 6: prior term, total, ln2 scaling, output saturation
   logic                 s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic signed [31:0]   s4_acc_ff, s4_prior_ff, s5_tot_ff;
   logic signed [49:0]   s6_p_ff;
   nbpc_pkg::lclass_type s4_class_ff, s5_class_ff, s6_class_ff;
   logic signed [33:0]   tot_sum, q;
   logic signed [31:0]   tot_sat;
   logic signed [23:0]   score_sat;

   assign tot_sum = 34'(s4_acc_ff) + 34'(s4_prior_ff);
   always_comb begin
      priority if (tot_sum > ACC_MAX) tot_sat = 32'(ACC_MAX);
      else if (tot_sum < ACC_MIN)     tot_sat = 32'(ACC_MIN);
      else                            tot_sat = 32'(tot_sum);
   end

   assign q = 34'(s6_p_ff >>> 16);
   always_comb begin
      priority if (q > SCORE_MAX) score_sat = 24'(SCORE_MAX);
      else if (q < SCORE_MIN)     score_sat = 24'(SCORE_MIN);
      else                        score_sat = 24'(q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_acc_ff   <= s3_acc_ff;
      s4_class_ff <= s3_class_ff;
      s4_prior_ff <= 32'(s3_prior_ff) * 32'(PIX_S);
      s5_tot_ff   <= tot_sat;
      s5_class_ff <= s4_class_ff;
      s6_p_ff     <= 50'(s5_tot_ff) * 50'(nbpc_pkg::LN2_Q16) + 50'(nbpc_pkg::ROUND_Q16);
      s6_class_ff <= s5_class_ff;
   end

   assign res_valid = s6_valid_ff;
   assign res_score = (s6_class_ff == nbpc_pkg::CL_FIN) ? score_sat : '0;
   assign res_class = s6_class_ff;
endmodule

// ===== hdl/naive_bayes_pixel_classifier.sv =====
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier
// Two-class naive Bayes over streamed grayscale pixels, Q8 log-ratio score.
// ----------------------------------------------------------------------------
// Takes one pixel per clock cycle, train or classify alike, with no stall as
// long as the score stream is drained; the count tables are read into a
// register and written back from stage 1, with a forwarding register so that
// neighboring pixels at the same entry stay correct. After reset, and after
// every clear action, a clearing pass zeroes both tables one entry per cycle,
// all IMAGE_WIDTH*IMAGE_HEIGHT*GRAY_LEVELS entries (16384 at the defaults),
// during which no pixel is taken.
`include "naive_bayes_pixel_classifier_defines.svh"

module naive_bayes_pixel_classifier #(
   parameter int IMAGE_WIDTH  = 32,
   parameter int IMAGE_HEIGHT = 32,
   parameter int GRAY_LEVELS  = 16,
   parameter int COUNT_BITS   = 16
) (
   input logic        clock,
   input logic        reset,
   nbpc_req_if.sink   req_chan,
   nbpc_rsp_if.source rsp_chan
);
   localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int CMD_W  = $bits(nbpc_pkg::cmd_type);
   localparam int RES_W  = nbpc_pkg::SCORE_W + 2;

   nbpc_pkg::cmd_type         front_cmd, queue_cmd;
   logic [CMD_W-1:0]          queue_out;
   logic                      front_valid, queue_ready, queue_valid;
   nbpc_pkg::back_status_type status;
   logic                      res_valid, res_ready, rsp_taken;
   logic signed [23:0]        res_score;
   logic [1:0]                res_class;
   logic [RES_W-1:0]          rsp_data;

   // front end
   nbpc_front #(.PIXELS(PIXELS), .GRAY_LEVELS(GRAY_LEVELS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .status    (status),
      .cmd_valid (front_valid),
      .cmd_ready (queue_ready),
      .cmd       (front_cmd)
   );

   // command queue between the two halves
   nbpc_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (queue_ready),
      .in_data   (front_cmd),
      .out_valid (queue_valid),
      .out_ready (status.cmd_pop),
      .out_data  (queue_out)
   );
   assign queue_cmd = nbpc_pkg::cmd_type'(queue_out);

   // back end
   nbpc_back #(
      .PIXELS      (PIXELS),
      .GRAY_LEVELS (GRAY_LEVELS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .status    (status),
      .res_valid (res_valid),
      .res_score (res_score),
      .res_class (res_class),
      .rsp_taken (rsp_taken)
   );

   // score queue toward the response channel
   nbpc_fifo #(.WIDTH(RES_W), .DEPTH(nbpc_pkg::RSP_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   ({res_score, res_class}),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );
   assign rsp_chan.score       = $signed(rsp_data[RES_W-1:2]);
   assign rsp_chan.score_class = rsp_data[1:0];
   assign rsp_taken            = rsp_chan.valid && rsp_chan.ready;

   // credits must keep the score queue from overflowing
   `NBPC_ASSERT_IMPLIES(a_rsp_no_overflow, res_valid, res_ready)
   // no pixel is taken while the tables are swept
   `NBPC_ASSERT_IMPLIES(a_no_accept_clearing, status.clearing, !req_chan.ready)
   // back end holds off the queue during a sweep
   `NBPC_ASSERT_NEVER(a_no_pop_clearing, status.clearing && status.cmd_pop)
endmodule
